// ----- rtl/core/cstg_pkg.sv -----
`timescale 1ns / 1ps
package cstg_pkg;
  localparam int SPAN_W    = 19;
  localparam int STEP_W    = 17;
  localparam int LEFT_W    = 13;
  localparam int WIDTH_W   = 12;
  localparam int MAXT_W    = 7;
  localparam int HEAD_W    = 21;
  localparam int BEAR_W    = 19;
  localparam int REL_W     = 19;
  localparam int X_W       = 18;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 19;

  localparam int DEF_MAX_TICKS = 64;

  localparam logic [SPAN_W-1:0]  DEF_SPAN  = 19'd120000;
  localparam logic [STEP_W-1:0]  DEF_STEP  = 17'd15000;
  localparam logic [WIDTH_W-1:0] DEF_WIDTH = 12'd256;
  localparam logic [MAXT_W-1:0]  DEF_MAXT  = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_SPAN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXT  = 3'd4;

  localparam int FULL_CIRCLE = 360000;
  localparam int OCTANT      = 45000;
endpackage

// ----- rtl/core/compass_strip_tick_generator.sv -----
`timescale 1ns / 1ps
// sequence: prepare, divide, first-tick quotient and multiply, wrap steps, window check; then
// multiply, divide and emit per tick; an empty window goes from the check to the empty result;
// output stalls hold the emit and empty states; the divides use the 40-step shared restoring divider
// (one pass for the first tick bearing, one pass per tick for the x position)
// one heading at a time: in_stall is high from acceptance until the last result is loaded
// rst is synchronous, active high, and restores the default register values
module compass_strip_tick_generator #(
  parameter int MAX_TICKS = cstg_pkg::DEF_MAX_TICKS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cstg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cstg_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cstg_pkg::HEAD_W-1:0]  heading_mdeg,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                tick_valid,
  output logic [cstg_pkg::BEAR_W-1:0]         tick_bearing,
  output logic signed [cstg_pkg::REL_W-1:0]   tick_relative,
  output logic signed [cstg_pkg::X_W-1:0]     tick_x,
  output logic [1:0]                          tick_rank,
  output logic [2:0]                          label_index,
  output logic                                last
);
  localparam int CW  = $clog2(MAX_TICKS + 1);
  localparam int NW  = 40;
  localparam int DW  = 20;
  localparam int BW  = 22;
  localparam int HW2 = 24;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_FIRSTQ = 4'd3;
  localparam logic [3:0] S_FIRSTM = 4'd4;
  localparam logic [3:0] S_WRAP   = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_XNUM   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_EMPTY  = 4'd10;

  localparam logic signed [BW-1:0] CIRCLE = BW'(cstg_pkg::FULL_CIRCLE);

  logic [cstg_pkg::SPAN_W-1:0]         span_mdeg;
  logic [cstg_pkg::STEP_W-1:0]         step_mdeg;
  logic signed [cstg_pkg::LEFT_W-1:0]  strip_left;
  logic [cstg_pkg::WIDTH_W-1:0]        strip_width;
  logic [cstg_pkg::MAXT_W-1:0]         max_ticks;

  logic [3:0] state;
  logic signed [cstg_pkg::HEAD_W-1:0] head;
  logic [cstg_pkg::SPAN_W-1:0]  sp;
  logic [cstg_pkg::STEP_W-1:0]  st;
  logic [CW-1:0]                cap;
  logic [CW-1:0]                n;
  logic signed [HW2-1:0]        hi2;
  logic signed [37:0]           base;
  logic signed [31:0]           prw;
  logic signed [BW-1:0]         b;
  logic signed [BW-1:0]         wb;
  logic signed [12:0]           q;
  logic                         dneg;
  logic                         dpos;
  logic                         div_x;

  // shared restoring divider
  logic [NW-1:0] dnum;
  logic [DW-1:0] drem;
  logic [DW-1:0] ddiv;
  logic [5:0]    dcnt;
  logic [DW:0]   trial;
  logic          tbit;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      span_mdeg   <= cstg_pkg::DEF_SPAN;
      step_mdeg   <= cstg_pkg::DEF_STEP;
      strip_left  <= '0;
      strip_width <= cstg_pkg::DEF_WIDTH;
      max_ticks   <= cstg_pkg::DEF_MAXT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cstg_pkg::REG_SPAN:  span_mdeg   <= cfg_data[cstg_pkg::SPAN_W-1:0];
        cstg_pkg::REG_STEP:  step_mdeg   <= cfg_data[cstg_pkg::STEP_W-1:0];
        cstg_pkg::REG_LEFT:  strip_left  <= $signed(cfg_data[cstg_pkg::LEFT_W-1:0]);
        cstg_pkg::REG_WIDTH: strip_width <= cfg_data[cstg_pkg::WIDTH_W-1:0];
        cstg_pkg::REG_MAXT:  max_ticks   <= cfg_data[cstg_pkg::MAXT_W-1:0];
        default: ;
      endcase
    end
  end

  // combinational helpers
  localparam int X_W_L = cstg_pkg::X_W;
  logic [cstg_pkg::SPAN_W-1:0] span_eff;
  logic [cstg_pkg::STEP_W-1:0] step_eff;
  logic [CW-1:0]               cap_eff;
  logic signed [HW2-1:0]       a_val;
  logic [HW2-1:0]              a_mag;
  logic signed [17:0]          bl;
  logic signed [NW-1:0]        xn;
  logic [NW-1:0]               xn_mag;
  logic signed [BW-1:0]        b_nxt;
  logic signed [BW-1:0]        wb_nxt;
  logic signed [BW-1:0]        rel;
  logic                        more;
  logic                        ofree;
  logic [1:0]                  rank;
  logic [2:0]                  lab;
  logic [X_W_L-1:0]            xq;

  always_comb begin
    span_eff = (span_mdeg > 19'd1000 && span_mdeg <= 19'd360000) ? span_mdeg
               : cstg_pkg::DEF_SPAN;
    step_eff = (step_mdeg >= 17'd1000 && step_mdeg <= 17'd90000) ? step_mdeg
               : cstg_pkg::DEF_STEP;
    cap_eff  = ({1'b0, max_ticks} > 8'(MAX_TICKS)) ? CW'(MAX_TICKS) : CW'(max_ticks);
    a_val  = ($signed({{(HW2-cstg_pkg::HEAD_W){head[cstg_pkg::HEAD_W-1]}}, head}) <<< 1)
             - $signed({{(HW2-cstg_pkg::SPAN_W){1'b0}}, sp});
    a_mag  = a_val[HW2-1] ? HW2'(-a_val) : HW2'(a_val);
    bl     = ($signed({{5{strip_left[cstg_pkg::LEFT_W-1]}}, strip_left}) <<< 4)
             + $signed({3'b0, strip_width, 3'b0});
    xn     = $signed({{(NW-38){base[37]}}, base})
             + ($signed({{(NW-32){prw[31]}}, prw}) <<< 4);
    xn_mag = xn[NW-1] ? NW'(-xn) : NW'(xn);
    b_nxt  = b + $signed({{(BW-cstg_pkg::STEP_W){1'b0}}, st});
    wb_nxt = wb + $signed({{(BW-cstg_pkg::STEP_W){1'b0}}, st});
    if (wb_nxt >= CIRCLE) wb_nxt = wb_nxt - CIRCLE;
    rel    = b - $signed({{(BW-cstg_pkg::HEAD_W){head[cstg_pkg::HEAD_W-1]}}, head});
    more   = ({1'b0, n} + (CW+1)'(1) < {1'b0, cap})
             && (($signed({{(HW2-BW){b_nxt[BW-1]}}, b_nxt}) <<< 1) <= hi2);
    ofree  = !out_valid || !out_stall;
    rank   = 2'd0;
    lab    = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (wb == BW'(k * cstg_pkg::OCTANT)) begin
        rank = (k % 2 == 0) ? 2'd2 : 2'd1;
        lab  = 3'(k);
      end
    end
    xq     = dneg ? X_W_L'(-dnum[X_W_L-1:0]) : dnum[X_W_L-1:0];
    trial  = {drem, dnum[NW-1]};
    tbit   = (trial >= {1'b0, ddiv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT || state == S_EMPTY) && ofree) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            head  <= heading_mdeg;
            sp    <= span_eff;
            st    <= step_eff;
            cap   <= cap_eff;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          hi2   <= ($signed({{(HW2-cstg_pkg::HEAD_W){head[cstg_pkg::HEAD_W-1]}}, head}) <<< 1)
                   + $signed({{(HW2-cstg_pkg::SPAN_W){1'b0}}, sp});
          base  <= bl * $signed({1'b0, sp});
          dnum  <= NW'(a_mag);
          drem  <= '0;
          ddiv  <= DW'({st, 1'b0});
          dcnt  <= '0;
          dneg  <= a_val[HW2-1];
          dpos  <= !a_val[HW2-1] && (a_val != '0);
          div_x <= 1'b0;
          state <= S_DIV;
        end
        S_DIV: begin
          drem <= tbit ? DW'(trial - {1'b0, ddiv}) : DW'(trial);
          dnum <= {dnum[NW-2:0], tbit};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(NW - 1)) state <= div_x ? S_EMIT : S_FIRSTQ;
        end
        S_FIRSTQ: begin
          // truncation is already the ceiling for negative numerators
          q <= dneg ? -$signed({1'b0, dnum[11:0]})
               : $signed({1'b0, dnum[11:0]}) + ((dpos && drem != '0) ? 13'sd1 : 13'sd0);
          state <= S_FIRSTM;
        end
        S_FIRSTM: begin
          b     <= BW'(q * $signed({1'b0, st}));
          wb    <= BW'(q * $signed({1'b0, st}));
          n     <= '0;
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (wb < 0) wb <= wb + CIRCLE;
          else if (wb >= CIRCLE) wb <= wb - CIRCLE;
          else state <= S_CHECK;
        end
        S_CHECK: begin
          if (cap != '0 && (($signed({{(HW2-BW){b[BW-1]}}, b}) <<< 1) <= hi2))
            state <= S_MUL;
          else
            state <= S_EMPTY;
        end
        S_MUL: begin
          prw   <= 32'(rel * $signed({1'b0, strip_width}));
          state <= S_XNUM;
        end
        S_XNUM: begin
          // round to nearest, ties away from zero
          dnum  <= (xn_mag << 1) + NW'(sp);
          drem  <= '0;
          ddiv  <= DW'({sp, 1'b0});
          dcnt  <= '0;
          dneg  <= xn[NW-1];
          div_x <= 1'b1;
          state <= S_DIV;
        end
        S_EMIT: begin
          if (ofree) begin
            tick_valid    <= 1'b1;
            tick_bearing  <= wb[cstg_pkg::BEAR_W-1:0];
            tick_relative <= rel[cstg_pkg::REL_W-1:0];
            tick_x        <= xq;
            tick_rank     <= rank;
            label_index   <= lab;
            last          <= !more;
            if (more) begin
              b     <= b_nxt;
              wb    <= wb_nxt;
              n     <= n + CW'(1);
              state <= S_MUL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (ofree) begin
            tick_valid    <= 1'b0;
            tick_bearing  <= '0;
            tick_relative <= '0;
            tick_x        <= '0;
            tick_rank     <= '0;
            label_index   <= '0;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
